/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and held off in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion violated");
// Antecedent in this cycle implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion violated");
`else
`define ASSERT_ALWAYS(lbl, prop)
`define ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* hdl/i2cbm_pkg.sv */
// ---------------------------------------------------------------------------
// i2cbm_pkg
// Types and constants of the byte-level I2C bit-bang master.
// ---------------------------------------------------------------------------
`default_nettype none

package i2cbm_pkg;

  localparam int unsigned TimerW    = 16;
  localparam int unsigned PollW     = 8;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned BitCntW   = 3;
  localparam int unsigned CmdW      = 3;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [TimerW-1:0]  PhaseTicksRst = 16'd5;
  localparam logic [PollW-1:0]   AckTimeoutRst = 8'd250;
  localparam logic [BitCntW-1:0] LastBit       = 3'd7;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPhaseTicks = 2'd0,
    CfgAckTimeout = 2'd1
  } cfg_idx_e;

  typedef enum logic [CmdW-1:0] {
    CmdNone  = 3'd0,
    CmdStart = 3'd1,
    CmdStop  = 3'd2,
    CmdWrite = 3'd3,
    CmdRead  = 3'd4
  } cmd_e;

  typedef enum logic [4:0] {
    PhIdle = 5'd0,
    PhS1   = 5'd1,
    PhS2   = 5'd2,
    PhS3   = 5'd3,
    PhP1   = 5'd4,
    PhP2   = 5'd5,
    PhP3   = 5'd6,
    PhW1   = 5'd7,
    PhW2   = 5'd8,
    PhW3   = 5'd9,
    PhA1   = 5'd10,
    PhA2   = 5'd11,
    PhA3   = 5'd12,
    PhR1   = 5'd13,
    PhR2   = 5'd14,
    PhK1   = 5'd15,
    PhK2   = 5'd16
  } phase_e;

  // Line levels driven toward the pads.
  typedef struct packed {
    logic scl;
    logic sda;
    logic drv;
  } lines_t;

endpackage

`default_nettype wire

/* hdl/i2c_bitbang_byte_master.sv */
// ---------------------------------------------------------------------------
// i2c_bitbang_byte_master
// Byte-level I2C master that sequences SCL and SDA one bus tick per item.
// ---------------------------------------------------------------------------
// Usage: every transaction on the input channel is one tick of the bus
// timebase. It carries an optional command (start, stop, write byte, read
// byte), the byte to send, the ack choice for a read and the sampled SDA
// level. Each accepted tick produces exactly one transaction on the output
// channel with the SCL/SDA levels, busy and done flags, the last received
// byte and the ack failure flag, all as they stand after that tick.
// The tick is evaluated in the cycle it is accepted and its result appears
// on the output register in the next cycle, so the block takes one tick per
// cycle while the receiver takes each result. The sequencer registers and the
// output register are both updated on each accepted tick.
// in_ready_o stays high while the output register is empty or is being
// taken in the same cycle; a stalled receiver holds the result and stops
// new ticks, so no result is lost. Configuration writes (phase_ticks,
// ack_timeout) are always taken and should only be issued while idle.
// Reset returns the sequencer to idle with SCL and SDA driven high, the held
// rx byte zero, phase_ticks 5 and ack_timeout 250; no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module i2c_bitbang_byte_master (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Tick input channel.
  input  wire logic                             in_valid_i,
  output      logic                             in_ready_o,
  input  wire logic [i2cbm_pkg::CmdW-1:0]       cmd_i,
  input  wire logic [i2cbm_pkg::ByteW-1:0]      tx_byte_i,
  input  wire logic                             send_ack_i,
  input  wire logic                             sda_in_i,
  // Result channel.
  output      logic                             out_valid_o,
  input  wire logic                             out_ready_i,
  output      logic                             scl_out_o,
  output      logic                             sda_out_o,
  output      logic                             sda_drive_o,
  output      logic                             busy_res_o,
  output      logic                             done_res_o,
  output      logic [i2cbm_pkg::ByteW-1:0]      rx_byte_o,
  output      logic                             ack_failed_o,
  // Configuration write channel.
  input  wire logic                             cfg_valid_i,
  output      logic                             cfg_ready_o,
  input  wire logic [i2cbm_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [i2cbm_pkg::CfgDataW-1:0]   cfg_data_i
);

  // Configuration registers.
  logic [i2cbm_pkg::TimerW-1:0] phase_ticks_q;
  logic [i2cbm_pkg::PollW-1:0]  ack_timeout_q;

  // Sequencer state.
  i2cbm_pkg::phase_e              phase_q, phase_d;
  logic [i2cbm_pkg::BitCntW-1:0]  bit_count_q, bit_count_d;
  logic [i2cbm_pkg::ByteW-1:0]    shift_q, shift_d;
  logic [i2cbm_pkg::TimerW-1:0]   timer_q, timer_d;
  logic [i2cbm_pkg::PollW-1:0]    poll_q, poll_d;
  i2cbm_pkg::lines_t              lines_q, lines_d;
  logic                           fail_q, fail_d;
  logic                           ack_choice_q, ack_choice_d;
  logic [i2cbm_pkg::ByteW-1:0]    rx_hold_q, rx_hold_d;

  // Output register.
  logic                           out_valid_q;
  logic                           scl_q, sda_q, drv_q, busy_q, done_q, fail_out_q;
  logic [i2cbm_pkg::ByteW-1:0]    rx_out_q;

  logic                           in_fire;
  logic                           done_d;
  logic                           expired;
  logic [i2cbm_pkg::TimerW-1:0]   timer_dec;
  logic [i2cbm_pkg::TimerW-1:0]   timer_load;
  logic                           sda_res, busy_res;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // A programmed phase length of zero behaves as one tick.
  assign timer_load = (phase_ticks_q == '0) ? {{(i2cbm_pkg::TimerW-1){1'b0}}, 1'b1}
                                            : phase_ticks_q;
  assign timer_dec  = timer_q - {{(i2cbm_pkg::TimerW-1){1'b0}}, 1'b1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= i2cbm_pkg::PhaseTicksRst;
      ack_timeout_q <= i2cbm_pkg::AckTimeoutRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        i2cbm_pkg::CfgPhaseTicks: phase_ticks_q <= cfg_data_i;
        i2cbm_pkg::CfgAckTimeout: ack_timeout_q <= cfg_data_i[i2cbm_pkg::PollW-1:0];
        default: ;
      endcase
    end
  end

  // Next-state logic: one bus tick.
  always_comb begin
    phase_d      = phase_q;
    bit_count_d  = bit_count_q;
    shift_d      = shift_q;
    timer_d      = timer_q;
    poll_d       = poll_q;
    lines_d      = lines_q;
    fail_d       = fail_q;
    ack_choice_d = ack_choice_q;
    rx_hold_d    = rx_hold_q;
    done_d       = 1'b0;
    expired      = 1'b0;

    if (in_fire) begin
      if (phase_q == i2cbm_pkg::PhIdle) begin
        // Commands are only taken while idle; unknown codes do nothing.
        unique case (cmd_i)
          i2cbm_pkg::CmdStart: begin
            lines_d = '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
            timer_d = timer_load;
            phase_d = i2cbm_pkg::PhS1;
          end
          i2cbm_pkg::CmdStop: begin
            lines_d = '{scl: 1'b0, sda: 1'b0, drv: 1'b1};
            timer_d = timer_load;
            phase_d = i2cbm_pkg::PhP1;
          end
          i2cbm_pkg::CmdWrite: begin
            fail_d      = 1'b0;
            shift_d     = tx_byte_i;
            bit_count_d = '0;
            lines_d     = '{scl: 1'b0, sda: tx_byte_i[i2cbm_pkg::ByteW-1], drv: 1'b1};
            timer_d     = timer_load;
            phase_d     = i2cbm_pkg::PhW1;
          end
          i2cbm_pkg::CmdRead: begin
            ack_choice_d = send_ack_i;
            shift_d      = '0;
            bit_count_d  = '0;
            lines_d      = '{scl: 1'b0, sda: 1'b1, drv: 1'b0};
            timer_d      = timer_load;
            phase_d      = i2cbm_pkg::PhR1;
          end
          default: ;
        endcase
      end else if (phase_q == i2cbm_pkg::PhA3) begin
        // Ack poll with SCL high, one sample per tick.
        if (!sda_in_i) begin
          lines_d.scl = 1'b0;
          phase_d     = i2cbm_pkg::PhIdle;
          done_d      = 1'b1;
        end else if (poll_q >= ack_timeout_q) begin
          fail_d  = 1'b1;
          lines_d = '{scl: 1'b0, sda: 1'b0, drv: 1'b1};
          timer_d = timer_load;
          phase_d = i2cbm_pkg::PhP1;
        end else begin
          poll_d = poll_q + {{(i2cbm_pkg::PollW-1){1'b0}}, 1'b1};
        end
      end else begin
        timer_d = timer_dec;
        expired = (timer_dec == '0);
      end

      if (expired) begin
        unique case (phase_q) inside
          i2cbm_pkg::PhS1: begin
            lines_d.sda = 1'b0; timer_d = timer_load; phase_d = i2cbm_pkg::PhS2;
          end
          i2cbm_pkg::PhS2: begin
            lines_d.scl = 1'b0; timer_d = timer_load; phase_d = i2cbm_pkg::PhS3;
          end
          i2cbm_pkg::PhP1: begin
            lines_d.scl = 1'b1; timer_d = timer_load; phase_d = i2cbm_pkg::PhP2;
          end
          i2cbm_pkg::PhP2: begin
            lines_d.sda = 1'b1; timer_d = timer_load; phase_d = i2cbm_pkg::PhP3;
          end
          i2cbm_pkg::PhW1: begin
            lines_d.scl = 1'b1; timer_d = timer_load; phase_d = i2cbm_pkg::PhW2;
          end
          i2cbm_pkg::PhW2: begin
            lines_d.scl = 1'b0; timer_d = timer_load; phase_d = i2cbm_pkg::PhW3;
          end
          i2cbm_pkg::PhW3: begin
            if (bit_count_q == i2cbm_pkg::LastBit) begin
              bit_count_d = '0;
              lines_d     = '{scl: 1'b0, sda: 1'b1, drv: 1'b0};
              phase_d     = i2cbm_pkg::PhA1;
            end else begin
              bit_count_d = bit_count_q + {{(i2cbm_pkg::BitCntW-1){1'b0}}, 1'b1};
              shift_d     = {shift_q[i2cbm_pkg::ByteW-2:0], 1'b0};
              lines_d.sda = shift_q[i2cbm_pkg::ByteW-2];
              phase_d     = i2cbm_pkg::PhW1;
            end
            timer_d = timer_load;
          end
          i2cbm_pkg::PhA1: begin
            lines_d.scl = 1'b1; timer_d = timer_load; phase_d = i2cbm_pkg::PhA2;
          end
          i2cbm_pkg::PhA2: begin
            // The poll phase runs on the sampled SDA, not on the timer.
            poll_d  = '0;
            phase_d = i2cbm_pkg::PhA3;
          end
          i2cbm_pkg::PhR1: begin
            lines_d.scl = 1'b1;
            shift_d     = {shift_q[i2cbm_pkg::ByteW-2:0], sda_in_i};
            timer_d     = timer_load;
            phase_d     = i2cbm_pkg::PhR2;
          end
          i2cbm_pkg::PhR2: begin
            if (bit_count_q == i2cbm_pkg::LastBit) begin
              bit_count_d = '0;
              rx_hold_d   = shift_q;
              lines_d     = '{scl: 1'b0, sda: !ack_choice_q, drv: 1'b1};
              phase_d     = i2cbm_pkg::PhK1;
            end else begin
              bit_count_d = bit_count_q + {{(i2cbm_pkg::BitCntW-1){1'b0}}, 1'b1};
              lines_d.scl = 1'b0;
              phase_d     = i2cbm_pkg::PhR1;
            end
            timer_d = timer_load;
          end
          i2cbm_pkg::PhK1: begin
            lines_d.scl = 1'b1; timer_d = timer_load; phase_d = i2cbm_pkg::PhK2;
          end
          i2cbm_pkg::PhK2: begin
            lines_d.scl = 1'b0; phase_d = i2cbm_pkg::PhIdle; done_d = 1'b1;
          end
          i2cbm_pkg::PhS3, i2cbm_pkg::PhP3: begin
            phase_d = i2cbm_pkg::PhIdle; done_d = 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // Result formatting from the post-tick state.
  always_comb begin
    sda_res  = lines_d.drv ? lines_d.sda : 1'b1;
    busy_res = (phase_d != i2cbm_pkg::PhIdle);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= i2cbm_pkg::PhIdle;
      bit_count_q  <= '0;
      shift_q      <= '0;
      timer_q      <= '0;
      poll_q       <= '0;
      lines_q      <= '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
      fail_q       <= 1'b0;
      ack_choice_q <= 1'b0;
      rx_hold_q    <= '0;
    end else begin
      phase_q      <= phase_d;
      bit_count_q  <= bit_count_d;
      shift_q      <= shift_d;
      timer_q      <= timer_d;
      poll_q       <= poll_d;
      lines_q      <= lines_d;
      fail_q       <= fail_d;
      ack_choice_q <= ack_choice_d;
      rx_hold_q    <= rx_hold_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      scl_q      <= lines_d.scl;
      sda_q      <= sda_res;
      drv_q      <= lines_d.drv;
      busy_q     <= busy_res;
      done_q     <= done_d;
      rx_out_q   <= rx_hold_d;
      fail_out_q <= fail_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign scl_out_o    = scl_q;
  assign sda_out_o    = sda_q;
  assign sda_drive_o  = drv_q;
  assign busy_res_o   = busy_q;
  assign done_res_o   = done_q;
  assign rx_byte_o    = rx_out_q;
  assign ack_failed_o = fail_out_q;

  // The held result always describes the current sequencer state.
  `ASSERT_ALWAYS(a_busy_matches_phase,
                 !out_valid_q || (busy_q == (phase_q != i2cbm_pkg::PhIdle)))
  // A completing tick leaves the sequencer idle.
  `ASSERT_ALWAYS(a_done_not_busy, !(out_valid_q && done_q && busy_q))
  // A low SDA sample during the ack poll ends the write.
  `ASSERT_NEXT(a_ack_ends_write,
               in_fire && (phase_q == i2cbm_pkg::PhA3) && !sda_in_i,
               (phase_q == i2cbm_pkg::PhIdle) && done_q)
  // A released SDA always reports a high level.
  `ASSERT_ALWAYS(a_released_sda_high, !out_valid_q || drv_q || sda_q)

endmodule

`default_nettype wire
